### rtl/core/least_loaded_replica_picker_unit_defines.svh
// Assertion macros for the replica picker.
`ifndef LEAST_LOADED_REPLICA_PICKER_UNIT_DEFINES_SVH
`define LEAST_LOADED_REPLICA_PICKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LLRP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
`define LLRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LLRP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define LLRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

### rtl/core/llrp_pkg.sv
`default_nettype none
package llrp_pkg;

  localparam int ID_W          = 8;
  localparam int LOAD_W        = 16;
  localparam int REP_FIELDS    = 3;
  localparam int REP_IDX_W     = 2;
  localparam int SLOT_OUT_W    = 4;
  localparam int CFG_W         = 5;
  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_REPLICAS  = 3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_ASSIGN = 1'b1;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [LOAD_W-1:0] load;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic                  valid;
    logic [REP_IDX_W-1:0]  chosen_replica;
    logic [SLOT_OUT_W-1:0] chosen_slot;
    logic                  no_match;
    logic                  was_assignment;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/llrp_slot_mem.sv
`default_nettype none
module llrp_slot_mem
  import llrp_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_NODES,
  parameter int AW    = $clog2(DEF_MAX_NODES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  output entry_t             rd_data
);

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   written_r;
  entry_t             rd_raw_r;
  logic               rd_hit_r;

  // valid bits stand in for the all-zero reset of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_hit_r  <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rd_hit_r <= written_r[rd_addr];
      end
      if (ctl.wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_hit_r ? rd_raw_r : '0;

endmodule
`default_nettype wire

### rtl/core/llrp_ctrl.sv
`default_nettype none
module llrp_ctrl
  import llrp_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int REPLICAS  = DEF_REPLICAS,
  parameter int SLOT_W    = $clog2(DEF_MAX_NODES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  command,
  input  wire logic [SLOT_OUT_W-1:0] slot_index,
  input  wire logic [ID_W-1:0]       slot_node_id,
  input  wire logic [ID_W-1:0]       replica0_node,
  input  wire logic [ID_W-1:0]       replica1_node,
  input  wire logic [ID_W-1:0]       replica2_node,
  input  wire logic [CFG_W-1:0]      nodes_cfg,
  output mem_ctl_t                   mem_ctl,
  output logic [SLOT_W-1:0]          rd_addr,
  output logic [SLOT_W-1:0]          wr_addr,
  output entry_t                     wr_data,
  input  wire entry_t                rd_data,
  output result_t                    res
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int REP_N = (REPLICAS < REP_FIELDS) ? REPLICAS : REP_FIELDS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  scan_len_r, scan_len_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] cmp_slot_r, cmp_slot_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  logic [REP_IDX_W-1:0] best_rep_r, best_rep_nxt;
  logic [LOAD_W-1:0] best_load_r, best_load_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [ID_W-1:0]   rep_r [REP_FIELDS];
  logic [ID_W-1:0]   rep_nxt [REP_FIELDS];
  result_t           res_r, res_nxt;

  logic              accept;
  logic              hit;
  logic [REP_IDX_W-1:0] hit_rep;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign rd_addr = issue_r[SLOT_W-1:0];
  assign res     = res_r;

  // first replica whose node id matches the entry being compared
  always_comb begin
    hit     = 1'b0;
    hit_rep = '0;
    for (int r = REP_N - 1; r >= 0; r--) begin
      if (rep_r[r] == rd_data.node_id) begin
        hit     = 1'b1;
        hit_rep = REP_IDX_W'(r);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_len_nxt  = scan_len_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    cmp_slot_nxt  = cmp_slot_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_rep_nxt  = best_rep_r;
    best_load_nxt = best_load_r;
    best_id_nxt   = best_id_r;
    rep_nxt       = rep_r;
    res_nxt       = '0;
    mem_ctl       = '0;
    wr_addr       = '0;
    wr_data       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_WRITE) begin
            mem_ctl.wr_en = (32'(slot_index) < MAX_NODES);
            wr_addr       = SLOT_W'(slot_index);
            wr_data       = '{node_id: slot_node_id, load: '0};
            res_nxt.valid = 1'b1;
          end else begin
            rep_nxt[0]   = replica0_node;
            rep_nxt[1]   = replica1_node;
            rep_nxt[2]   = replica2_node;
            scan_len_nxt = (int'(nodes_cfg) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(nodes_cfg);
            issue_nxt    = '0;
            pend_nxt     = 1'b0;
            found_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read of slot k overlaps the compare of slot k-1
        mem_ctl.rd_en = (issue_r < scan_len_r);
        if (mem_ctl.rd_en) begin
          issue_nxt = issue_r + 1'b1;
        end
        pend_nxt     = mem_ctl.rd_en;
        cmp_slot_nxt = issue_r[SLOT_W-1:0];
        if (pend_r && hit && (!found_r || rd_data.load < best_load_r)) begin
          found_nxt     = 1'b1;
          best_slot_nxt = cmp_slot_r;
          best_rep_nxt  = hit_rep;
          best_load_nxt = rd_data.load;
          best_id_nxt   = rd_data.node_id;
        end
        if (!mem_ctl.rd_en && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        mem_ctl.wr_en = found_r;
        wr_addr       = best_slot_r;
        wr_data       = '{node_id: best_id_r,
                          load: (best_load_r == LOAD_MAX) ? best_load_r
                                                          : best_load_r + 1'b1};
        res_nxt.valid          = 1'b1;
        res_nxt.was_assignment = 1'b1;
        res_nxt.no_match       = !found_r;
        if (found_r) begin
          res_nxt.chosen_replica = best_rep_r;
          res_nxt.chosen_slot    = SLOT_OUT_W'(best_slot_r);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_len_r  <= scan_len_nxt;
    issue_r     <= issue_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    best_slot_r <= best_slot_nxt;
    best_rep_r  <= best_rep_nxt;
    best_load_r <= best_load_nxt;
    best_id_r   <= best_id_nxt;
    rep_r       <= rep_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/least_loaded_replica_picker_unit.sv
// Write command: table written at the transfer, acknowledge strobed the next cycle; 1 item/cycle
//   while busy is low. Assign command: busy while it scans N = min(nodes_in_use, MAX_NODES) slots;
//   result strobed in the same cycle that busy drops, and the next start is taken in that cycle.
// The scan makes one slot-table read per slot, drains the read and compare, then writes back.
// Results cannot be stalled. Synchronous active-low reset: table and counters read as zero
//   (per-slot valid bits), nodes_in_use returns to 1, no result pending.
`default_nettype none
`include "least_loaded_replica_picker_unit_defines.svh"
module least_loaded_replica_picker_unit
  import llrp_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int REPLICAS  = DEF_REPLICAS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_command,
  input  wire logic [SLOT_OUT_W-1:0] in_slot_index,
  input  wire logic [ID_W-1:0]       in_slot_node_id,
  input  wire logic [ID_W-1:0]       in_replica0_node,
  input  wire logic [ID_W-1:0]       in_replica1_node,
  input  wire logic [ID_W-1:0]       in_replica2_node,
  output logic                       out_valid,
  output logic [REP_IDX_W-1:0]       out_chosen_replica,
  output logic [SLOT_OUT_W-1:0]      out_chosen_slot,
  output logic                       out_no_match,
  output logic                       out_was_assignment,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int SLOT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [CFG_W-1:0]  nodes_in_use_r;
  mem_ctl_t          mem_ctl;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  result_t           res;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_in_use_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      nodes_in_use_r <= cfg_data;
    end
  end

  llrp_ctrl #(
    .MAX_NODES (MAX_NODES),
    .REPLICAS  (REPLICAS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .command       (in_command),
    .slot_index    (in_slot_index),
    .slot_node_id  (in_slot_node_id),
    .replica0_node (in_replica0_node),
    .replica1_node (in_replica1_node),
    .replica2_node (in_replica2_node),
    .nodes_cfg     (nodes_in_use_r),
    .mem_ctl       (mem_ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_data       (rd_data),
    .res           (res)
  );

  llrp_slot_mem #(
    .DEPTH (MAX_NODES),
    .AW    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign out_valid          = res.valid;
  assign out_chosen_replica = res.chosen_replica;
  assign out_chosen_slot    = res.chosen_slot;
  assign out_no_match       = res.no_match;
  assign out_was_assignment = res.was_assignment;

  `LLRP_ASSERT_NEXT(a_write_ack, clk, rst_n, start && !busy && in_command == CMD_WRITE, out_valid && !out_was_assignment, "write transfer not acknowledged")
  `LLRP_ASSERT_NEXT(a_assign_busy, clk, rst_n, start && !busy && in_command == CMD_ASSIGN, busy && !out_valid, "assign transfer did not start a scan")
  `LLRP_ASSERT_IMPL(a_assign_after_scan, clk, rst_n, out_valid && out_was_assignment, $past(busy), "assign result without a scan")
  `LLRP_ASSERT_IMPL(a_no_match_clean, clk, rst_n, out_valid && out_no_match, out_chosen_slot == '0 && out_chosen_replica == '0 && out_was_assignment, "no-match result carries a selection")

endmodule
`default_nettype wire

### dv/least_loaded_replica_picker_unit_tb.sv
`timescale 1ns / 100ps

module least_loaded_replica_picker_unit_tb;
  import llrp_pkg::*;

  localparam int MAX_SLOTS = DEF_MAX_NODES;

  typedef struct packed {
    logic                  command;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [ID_W-1:0]       slot_node_id;
    logic [ID_W-1:0]       rep0;
    logic [ID_W-1:0]       rep1;
    logic [ID_W-1:0]       rep2;
  } node_cmd_t;

  typedef struct packed {
    logic [REP_IDX_W-1:0]  chosen_replica;
    logic [SLOT_OUT_W-1:0] chosen_slot;
    logic                  no_match;
    logic                  was_assignment;
  } pick_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_command = 1'b0;
  logic [SLOT_OUT_W-1:0] in_slot_index = '0;
  logic [ID_W-1:0]       in_slot_node_id = '0;
  logic [ID_W-1:0]       in_replica0_node = '0;
  logic [ID_W-1:0]       in_replica1_node = '0;
  logic [ID_W-1:0]       in_replica2_node = '0;
  logic                  out_valid;
  logic [REP_IDX_W-1:0]  out_chosen_replica;
  logic [SLOT_OUT_W-1:0] out_chosen_slot;
  logic                  out_no_match;
  logic                  out_was_assignment;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  least_loaded_replica_picker_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_slot_index     (in_slot_index),
    .in_slot_node_id   (in_slot_node_id),
    .in_replica0_node  (in_replica0_node),
    .in_replica1_node  (in_replica1_node),
    .in_replica2_node  (in_replica2_node),
    .out_valid         (out_valid),
    .out_chosen_replica(out_chosen_replica),
    .out_chosen_slot   (out_chosen_slot),
    .out_no_match      (out_no_match),
    .out_was_assignment(out_was_assignment),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // shadow of the slot table and the node count register
  logic [ID_W-1:0]   slot_ids   [MAX_SLOTS];
  logic [LOAD_W-1:0] slot_loads [MAX_SLOTS];
  logic [CFG_W-1:0]  nodes_cfg;

  node_cmd_t cmd_backlog[$];
  pick_t     pending_picks[$];
  node_cmd_t live_cmd;
  logic [ID_W-1:0] id_pool [6];

  int idle_pct = 11;
  int cmds_queued = 0;
  int cmds_accepted = 0;
  int mismatches = 0;
  int writes_seen = 0;
  int assigns_seen = 0;
  int misses_seen = 0;
  int sat_hits = 0;
  int cfg_settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected outcome of one command; updates the shadow table.
  function automatic pick_t route_block(node_cmd_t c);
    pick_t             r;
    int                n;
    int                s;
    int                hit;
    int                best;
    int                best_rep;
    logic [LOAD_W-1:0] best_load;
    r = '0;
    if (c.command == CMD_WRITE) begin
      slot_ids[c.slot_index]   = c.slot_node_id;
      slot_loads[c.slot_index] = '0;
      writes_seen++;
      return r;
    end
    assigns_seen++;
    r.was_assignment = 1'b1;
    n = (nodes_cfg > MAX_SLOTS) ? MAX_SLOTS : int'(nodes_cfg);
    best = -1;
    best_rep = 0;
    best_load = '0;
    for (s = 0; s < n; s++) begin
      // lowest replica index on this node wins, so test from the top down
      hit = -1;
      if (c.rep2 == slot_ids[s]) hit = 2;
      if (c.rep1 == slot_ids[s]) hit = 1;
      if (c.rep0 == slot_ids[s]) hit = 0;
      if (hit >= 0 && (best < 0 || slot_loads[s] < best_load)) begin
        best = s;
        best_rep = hit;
        best_load = slot_loads[s];
      end
    end
    if (best < 0) begin
      r.no_match = 1'b1;
      misses_seen++;
      return r;
    end
    if (slot_loads[best] == LOAD_MAX) sat_hits++;
    else slot_loads[best] = slot_loads[best] + 1'b1;
    r.chosen_replica = best_rep[REP_IDX_W-1:0];
    r.chosen_slot = best[SLOT_OUT_W-1:0];
    return r;
  endfunction

  // driver: one command in flight on start/busy
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_picks.push_back(route_block(live_cmd));
        cmds_accepted++;
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          live_cmd = cmd_backlog.pop_front();
          start            <= 1'b1;
          in_command       <= live_cmd.command;
          in_slot_index    <= live_cmd.slot_index;
          in_slot_node_id  <= live_cmd.slot_node_id;
          in_replica0_node <= live_cmd.rep0;
          in_replica1_node <= live_cmd.rep1;
          in_replica2_node <= live_cmd.rep2;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results are strobed for one cycle and cannot be held off
  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (rst_n && out_valid) begin
      got = '{out_chosen_replica, out_chosen_slot, out_no_match, out_was_assignment};
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: replica %0d slot %0d miss %0b asg %0b",
                   $realtime, got.chosen_replica, got.chosen_slot, got.no_match,
                   got.was_assignment);
      end else begin
        want = pending_picks.pop_front();
        if (got.chosen_replica !== want.chosen_replica ||
            got.chosen_slot !== want.chosen_slot ||
            got.no_match !== want.no_match ||
            got.was_assignment !== want.was_assignment) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp replica %0d slot %0d miss %0b asg %0b, got %0d %0d %0b %0b",
                     $realtime, want.chosen_replica, want.chosen_slot, want.no_match,
                     want.was_assignment, got.chosen_replica, got.chosen_slot,
                     got.no_match, got.was_assignment);
        end
      end
    end
  end

  function automatic void queue_write(logic [SLOT_OUT_W-1:0] slot, logic [ID_W-1:0] id);
    node_cmd_t c;
    c.command = CMD_WRITE;
    c.slot_index = slot;
    c.slot_node_id = id;
    c.rep0 = ID_W'($urandom);
    c.rep1 = ID_W'($urandom);
    c.rep2 = ID_W'($urandom);
    cmd_backlog.push_back(c);
    cmds_queued++;
  endfunction

  function automatic void queue_assign(logic [ID_W-1:0] r0, logic [ID_W-1:0] r1,
                                       logic [ID_W-1:0] r2);
    node_cmd_t c;
    c.command = CMD_ASSIGN;
    c.slot_index = SLOT_OUT_W'($urandom);
    c.slot_node_id = ID_W'($urandom);
    c.rep0 = r0;
    c.rep1 = r1;
    c.rep2 = r2;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endfunction

  function automatic logic [ID_W-1:0] pool_or_any(int pct);
    return ($urandom_range(99) < pct) ? id_pool[$urandom_range(5)] : ID_W'($urandom);
  endfunction

  // mostly ids from a small pool so that assigns find candidates; some pure noise
  function automatic void queue_random_cmd();
    int span;
    span = (nodes_cfg == 0 || nodes_cfg > MAX_SLOTS) ? MAX_SLOTS : int'(nodes_cfg);
    if ($urandom_range(99) < 30) begin
      queue_write(($urandom_range(99) < 75) ? SLOT_OUT_W'($urandom_range(span - 1))
                                            : SLOT_OUT_W'($urandom_range(MAX_SLOTS - 1)),
                  pool_or_any(85));
    end else if ($urandom_range(99) < 10) begin
      queue_assign(ID_W'($urandom), ID_W'($urandom), ID_W'($urandom));
    end else begin
      queue_assign(pool_or_any(75), pool_or_any(75), pool_or_any(75));
    end
  endfunction

  task automatic wait_drained();
    while (cmds_accepted != cmds_queued || pending_picks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] v);
    wait_drained();
    repeat ($urandom_range(3)) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    nodes_cfg = v;
    cfg_valid <= 1'b0;
    cfg_settings++;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [8];
    int p;
    int i;
    int k;
    nodes_cfg = 5'd1;
    for (i = 0; i < MAX_SLOTS; i++) begin
      slot_ids[i] = '0;
      slot_loads[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset table is all zero with one slot in use
    queue_assign(8'h00, 8'h03, 8'h03);
    queue_assign(8'h07, 8'h07, 8'h00);
    queue_assign(8'h01, 8'h02, 8'h03);
    write_node_count(5'd16);
    queue_write(4'd0, 8'hFF);
    queue_write(4'd1, 8'h00);
    queue_write(4'd2, 8'hA5);
    queue_write(4'd15, 8'hFF);
    queue_write(4'd14, 8'h5A);
    queue_assign(8'hFF, 8'h5A, 8'h00);
    queue_assign(8'hFF, 8'h5A, 8'h00);
    queue_assign(8'hA5, 8'hA5, 8'hA5);
    queue_assign(8'h5A, 8'hFF, 8'hFF);
    queue_assign(8'h5A, 8'hFF, 8'hFF);
    queue_assign(8'h12, 8'h34, 8'h56);
    // zero slots in use: every assign misses
    write_node_count(5'd0);
    queue_assign(8'hFF, 8'hFF, 8'hFF);
    queue_write(4'd7, 8'h3C);
    // above the table size: clamps to all slots
    write_node_count(5'd31);
    queue_assign(8'h3C, 8'h00, 8'hFF);
    queue_assign(8'h00, 8'h00, 8'h3C);
    queue_assign(8'hA5, 8'h3C, 8'h5A);

    phase_cfg = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd9,
                  CFG_W'($urandom_range(31, 17)), CFG_W'($urandom_range(16, 2))};
    for (p = 0; p < 8; p++) begin
      write_node_count(phase_cfg[p]);
      for (k = 0; k < 6; k++)
        id_pool[k] = ($urandom_range(99) < 10) ? {ID_W{1'($urandom_range(1))}}
                                               : ID_W'($urandom);
      idle_pct = (p == 2) ? 0 : 11;
      for (i = 0; i < 206; i++) begin
        queue_random_cmd();
        // let the sender sit until the block has answered everything
        if (i == 103 && p % 3 == 1) wait_drained();
      end
    end

    // two slots on the same node: equal loads go to the lower slot, then alternate
    write_node_count(5'd2);
    queue_write(4'd0, 8'h42);
    queue_write(4'd1, 8'h42);
    for (i = 0; i < 6; i++) queue_assign(ID_W'($urandom), 8'h42, 8'h42);

    wait_drained();
    repeat (30) @(posedge clk);
    $display("Covered %0d commands: %0d slot writes, %0d assigns (%0d with no candidate node)",
             cmds_accepted, writes_seen, assigns_seen, misses_seen);
    $display("%0d node count settings, %0d assigns on a saturated load, %0d mismatches",
             cfg_settings, sat_hits, mismatches);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("least_loaded_replica_picker_unit verification clean");
    end else begin
      $display("least_loaded_replica_picker_unit verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("least_loaded_replica_picker_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/llrp_pkg.sv
rtl/core/llrp_slot_mem.sv
rtl/core/llrp_ctrl.sv
rtl/core/least_loaded_replica_picker_unit.sv
dv/least_loaded_replica_picker_unit_tb.sv
